### rtl/capacity_bounded_item_table_top_macros.svh
// ----------------------------------------------------------------------------
// capacity bounded item table assertion macros
// shared checking helpers, clocked on clk with rst_n as disable
// ----------------------------------------------------------------------------
`ifndef CAPACITY_BOUNDED_ITEM_TABLE_TOP_MACROS_SVH
`define CAPACITY_BOUNDED_ITEM_TABLE_TOP_MACROS_SVH

// property that must hold at every edge outside reset
`define CBIT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// trigger on one edge implies a consequence on the next edge
`define CBIT_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

### rtl/cbit_pkg.sv
// ----------------------------------------------------------------------------
// cbit_pkg
// shared types and constants of the capacity bounded item table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cbit_pkg;

    localparam int DEF_MAX_ENTRIES = 32;
    localparam int DEF_VALUE_BITS  = 32;
    localparam int CMD_BITS        = 3;
    localparam int CFG_INDEX_BITS  = 1;

    // default derived widths
    localparam int DEF_INDEX_BITS  = (DEF_MAX_ENTRIES > 1) ? $clog2(DEF_MAX_ENTRIES) : 1;
    localparam int DEF_COUNT_BITS  = $clog2(DEF_MAX_ENTRIES + 1);

    typedef enum logic [CMD_BITS-1:0] {
        CMD_ADD        = 3'd0,
        CMD_REMOVE_MIN = 3'd1,
        CMD_REMOVE_MAX = 3'd2,
        CMD_REMOVE_AT  = 3'd3,
        CMD_READ       = 3'd4
    } cbit_cmd_t;

    localparam logic [CFG_INDEX_BITS-1:0] REG_VOLUME_LIMIT = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WEIGHT_LIMIT = 1'd1;

endpackage

### rtl/cbit_if.sv
// ----------------------------------------------------------------------------
// cbit channel interfaces
// command, result and configuration channels with valid/ready handshake
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cbit_cmd_if #(
    parameter int VALUE_BITS = cbit_pkg::DEF_VALUE_BITS,
    parameter int INDEX_BITS = cbit_pkg::DEF_INDEX_BITS
);
    logic                          valid;
    logic                          ready;
    logic [cbit_pkg::CMD_BITS-1:0] command;
    logic [VALUE_BITS-1:0]         item_volume;
    logic [VALUE_BITS-1:0]         item_weight;
    logic [INDEX_BITS-1:0]         item_index;

    modport source (output valid, command, item_volume, item_weight, item_index,
                    input ready);
    modport sink   (input valid, command, item_volume, item_weight, item_index,
                    output ready);
endinterface

interface cbit_res_if #(
    parameter int VALUE_BITS = cbit_pkg::DEF_VALUE_BITS,
    parameter int COUNT_BITS = cbit_pkg::DEF_COUNT_BITS
);
    logic                  valid;
    logic                  ready;
    logic                  done_res;
    logic [VALUE_BITS-1:0] entry_volume;
    logic [VALUE_BITS-1:0] entry_weight;
    logic [COUNT_BITS-1:0] entry_count;
    logic [VALUE_BITS-1:0] used_volume;
    logic [VALUE_BITS-1:0] used_weight;

    modport source (output valid, done_res, entry_volume, entry_weight, entry_count,
                    used_volume, used_weight, input ready);
    modport sink   (input valid, done_res, entry_volume, entry_weight, entry_count,
                    used_volume, used_weight, output ready);
endinterface

interface cbit_cfg_if #(
    parameter int VALUE_BITS = cbit_pkg::DEF_VALUE_BITS
);
    logic                                valid;
    logic                                ready;
    logic [cbit_pkg::CFG_INDEX_BITS-1:0] index;
    logic [VALUE_BITS-1:0]               data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/capacity_bounded_item_table_top.sv
// path from accepted beat to result beat: add, unknown command, removal from an empty
// table and index out of range go straight to the emit state; read passes the read state;
// remove at index passes read, erase and, when entries follow it, shift; remove lightest
// or heaviest passes scan, erase and likewise shift; emit then waits while the result side
// holds off; one item at a time; slot scan and shift walk the slot ram one entry per cycle
// reset clears count, totals, limits and control; slot ram is not cleared
// ----------------------------------------------------------------------------
// capacity_bounded_item_table_top
// ordered table of volume/weight entries with capacity limits, held in one ram
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module capacity_bounded_item_table_top #(
    parameter int MAX_ENTRIES = cbit_pkg::DEF_MAX_ENTRIES,
    parameter int VALUE_BITS  = cbit_pkg::DEF_VALUE_BITS
) (
    input  logic       clk,
    input  logic       rst_n,
    cbit_cmd_if.sink   cmd,
    cbit_res_if.source res,
    cbit_cfg_if.sink   cfg
);

    import cbit_pkg::*;

    `include "capacity_bounded_item_table_top_macros.svh"

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int ENT_W = 2 * VALUE_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_ERASE,
        S_SHIFT,
        S_EMIT
    } state_t;

    // control and table state
    state_t                state_reg;
    cbit_cmd_t             cmd_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [VALUE_BITS-1:0] vol_total_reg;
    logic [VALUE_BITS-1:0] wt_total_reg;
    logic [VALUE_BITS-1:0] vol_limit_reg;
    logic [VALUE_BITS-1:0] wt_limit_reg;

    // walk pointers: scan read pointer, index of data now on the ram output,
    // erase position and shift write pointer
    logic [CNT_W-1:0]      scan_ptr_reg;
    logic [CNT_W-1:0]      data_idx_reg;
    logic [CNT_W-1:0]      pos_reg;
    logic [CNT_W-1:0]      wr_reg;

    // entry taken out of the table and done flag of the current item
    logic                  done_reg;
    logic [VALUE_BITS-1:0] ent_vol_reg;
    logic [VALUE_BITS-1:0] ent_wt_reg;

    // output register
    logic                  out_valid_reg;
    logic                  out_done_reg;
    logic [VALUE_BITS-1:0] out_ent_vol_reg;
    logic [VALUE_BITS-1:0] out_ent_wt_reg;
    logic [CNT_W-1:0]      out_count_reg;
    logic [VALUE_BITS-1:0] out_vol_total_reg;
    logic [VALUE_BITS-1:0] out_wt_total_reg;

    // slot ram, volume in the upper half, weight in the lower half
    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [ENT_W-1:0]      ram_wdata;
    logic [IDX_W-1:0]      ram_raddr;
    logic [ENT_W-1:0]      ram_rdata;
    logic [VALUE_BITS-1:0] rd_vol;
    logic [VALUE_BITS-1:0] rd_wt;

    logic                  in_beat;
    logic                  out_free;
    cbit_cmd_t             in_cmd;
    logic [CNT_W-1:0]      in_idx;
    logic [VALUE_BITS:0]   vol_sum;
    logic [VALUE_BITS:0]   wt_sum;
    logic                  add_ok;
    logic                  idx_ok;
    logic                  want_max;
    logic                  better;
    logic                  scan_last;
    logic [CNT_W:0]        pos_plus1;
    logic [CNT_W:0]        wr_plus2;
    logic                  more_after_pos;
    logic                  more_to_shift;
    logic                  emit_fire;
    logic                  shift_past_end;
    logic                  empty_removal;

    cbit_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_ENTRIES)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_vol = ram_rdata[ENT_W-1:VALUE_BITS];
    assign rd_wt  = ram_rdata[VALUE_BITS-1:0];

    // handshakes: new command only in idle, the output register frees on a taken beat
    assign cmd.ready = (state_reg == S_IDLE);
    assign in_beat   = cmd.valid && cmd.ready;
    assign out_free  = !out_valid_reg || res.ready;
    assign cfg.ready = 1'b1;

    assign in_cmd = cbit_cmd_t'(cmd.command);
    assign in_idx = CNT_W'(cmd.item_index);

    // capacity check: exact sums one bit wider than the totals
    assign vol_sum = {1'b0, vol_total_reg} + {1'b0, cmd.item_volume};
    assign wt_sum  = {1'b0, wt_total_reg} + {1'b0, cmd.item_weight};
    assign add_ok  = (count_reg < CNT_W'(MAX_ENTRIES))
                  && (vol_sum <= {1'b0, vol_limit_reg})
                  && (wt_sum <= {1'b0, wt_limit_reg});
    assign idx_ok  = (in_idx < count_reg);

    // scan: first slot seeds the best, strict compare keeps the lowest slot on ties
    assign want_max  = (cmd_reg == CMD_REMOVE_MAX);
    assign better    = (data_idx_reg == '0)
                    || (want_max ? (rd_wt > ent_wt_reg) : (rd_wt < ent_wt_reg));
    assign scan_last = (data_idx_reg == count_reg - CNT_W'(1));

    // shift bounds, compared one bit wider so the pointers never wrap
    assign pos_plus1      = {1'b0, pos_reg} + (CNT_W+1)'(1);
    assign wr_plus2       = {1'b0, wr_reg} + (CNT_W+1)'(2);
    assign more_after_pos = (pos_plus1 < {1'b0, count_reg});
    assign more_to_shift  = (wr_plus2 < {1'b0, count_reg});

    // finished item moves into the output register this cycle
    assign emit_fire = (state_reg == S_EMIT) && out_free;

    // ram port steering
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = count_reg[IDX_W-1:0];
        ram_wdata = {cmd.item_volume, cmd.item_weight};
        ram_raddr = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                // append at the tail on an accepted add
                if (in_beat && in_cmd == CMD_ADD && add_ok)
                begin
                    ram_we = 1'b1;
                end
                if (in_cmd == CMD_REMOVE_AT || in_cmd == CMD_READ)
                begin
                    ram_raddr = cmd.item_index;
                end
            end
            S_SCAN:
            begin
                ram_raddr = scan_ptr_reg[IDX_W-1:0];
            end
            S_ERASE:
            begin
                ram_raddr = pos_plus1[IDX_W-1:0];
            end
            S_SHIFT:
            begin
                // slot k+1 arrives, goes into slot k, slot k+2 is fetched
                ram_we    = 1'b1;
                ram_waddr = wr_reg[IDX_W-1:0];
                ram_wdata = ram_rdata;
                ram_raddr = wr_plus2[IDX_W-1:0];
            end
            S_READ, S_EMIT:
            begin
                ram_raddr = '0;
            end
            default:
            begin
                ram_raddr = '0;
            end
        endcase
    end

    // sequencer, table state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            cmd_reg           <= CMD_ADD;
            count_reg         <= '0;
            vol_total_reg     <= '0;
            wt_total_reg      <= '0;
            vol_limit_reg     <= '0;
            wt_limit_reg      <= '0;
            scan_ptr_reg      <= '0;
            data_idx_reg      <= '0;
            pos_reg           <= '0;
            wr_reg            <= '0;
            done_reg          <= 1'b0;
            ent_vol_reg       <= '0;
            ent_wt_reg        <= '0;
            out_valid_reg     <= 1'b0;
            out_done_reg      <= 1'b0;
            out_ent_vol_reg   <= '0;
            out_ent_wt_reg    <= '0;
            out_count_reg     <= '0;
            out_vol_total_reg <= '0;
            out_wt_total_reg  <= '0;
        end
        else
        begin
            // limit writes, to be made only while idle; the block itself does not enforce this
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    REG_VOLUME_LIMIT: vol_limit_reg <= cfg.data;
                    REG_WEIGHT_LIMIT: wt_limit_reg  <= cfg.data;
                endcase
            end

            // a taken beat empties the output register unless a new result loads it
            if (res.ready && !emit_fire)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_beat)
                    begin
                        cmd_reg     <= in_cmd;
                        done_reg    <= 1'b0;
                        ent_vol_reg <= '0;
                        ent_wt_reg  <= '0;
                        state_reg   <= S_EMIT;
                        unique case (in_cmd)
                            CMD_ADD:
                            begin
                                if (add_ok)
                                begin
                                    count_reg     <= count_reg + CNT_W'(1);
                                    vol_total_reg <= vol_sum[VALUE_BITS-1:0];
                                    wt_total_reg  <= wt_sum[VALUE_BITS-1:0];
                                    done_reg      <= 1'b1;
                                end
                            end
                            CMD_REMOVE_MIN, CMD_REMOVE_MAX:
                            begin
                                // slot 0 already requested this cycle
                                if (count_reg != '0)
                                begin
                                    scan_ptr_reg <= CNT_W'(1);
                                    data_idx_reg <= '0;
                                    state_reg    <= S_SCAN;
                                end
                            end
                            CMD_REMOVE_AT, CMD_READ:
                            begin
                                if (idx_ok)
                                begin
                                    pos_reg   <= in_idx;
                                    state_reg <= S_READ;
                                end
                            end
                            default:
                            begin
                                // unknown command: empty result
                                state_reg <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_SCAN:
                begin
                    scan_ptr_reg <= scan_ptr_reg + CNT_W'(1);
                    data_idx_reg <= data_idx_reg + CNT_W'(1);
                    if (better)
                    begin
                        pos_reg     <= data_idx_reg;
                        ent_vol_reg <= rd_vol;
                        ent_wt_reg  <= rd_wt;
                    end
                    if (scan_last)
                    begin
                        state_reg <= S_ERASE;
                    end
                end
                S_READ:
                begin
                    ent_vol_reg <= rd_vol;
                    ent_wt_reg  <= rd_wt;
                    if (cmd_reg == CMD_READ)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_ERASE;
                    end
                end
                S_ERASE:
                begin
                    // totals drop now; count drops now when no entry follows, else once the shift is over
                    done_reg      <= 1'b1;
                    vol_total_reg <= vol_total_reg - ent_vol_reg;
                    wt_total_reg  <= wt_total_reg - ent_wt_reg;
                    if (more_after_pos)
                    begin
                        wr_reg    <= pos_reg;
                        state_reg <= S_SHIFT;
                    end
                    else
                    begin
                        count_reg <= count_reg - CNT_W'(1);
                        state_reg <= S_EMIT;
                    end
                end
                S_SHIFT:
                begin
                    if (more_to_shift)
                    begin
                        wr_reg <= wr_reg + CNT_W'(1);
                    end
                    else
                    begin
                        count_reg <= count_reg - CNT_W'(1);
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg     <= 1'b1;
                        out_done_reg      <= done_reg;
                        out_ent_vol_reg   <= ent_vol_reg;
                        out_ent_wt_reg    <= ent_wt_reg;
                        out_count_reg     <= count_reg;
                        out_vol_total_reg <= vol_total_reg;
                        out_wt_total_reg  <= wt_total_reg;
                        state_reg         <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // result beat
    assign res.valid        = out_valid_reg;
    assign res.done_res     = out_done_reg;
    assign res.entry_volume = out_ent_vol_reg;
    assign res.entry_weight = out_ent_wt_reg;
    assign res.entry_count  = out_count_reg;
    assign res.used_volume  = out_vol_total_reg;
    assign res.used_weight  = out_wt_total_reg;

    // checks
    assign shift_past_end = (state_reg == S_SHIFT)
                         && ({1'b0, wr_reg} + (CNT_W+1)'(1) >= {1'b0, count_reg});
    assign empty_removal  = in_beat && (in_cmd == CMD_REMOVE_MIN || in_cmd == CMD_REMOVE_MAX)
                         && (count_reg == '0);

    `CBIT_ASSERT(a_count_bound, count_reg <= CNT_W'(MAX_ENTRIES), "held count above capacity")
    `CBIT_ASSERT(a_shift_in_table, !shift_past_end, "shift walks past the held entries")
    `CBIT_ASSERT_NEXT(a_emit_loads, emit_fire, out_valid_reg && cmd.ready, "result not loaded")
    `CBIT_ASSERT_NEXT(a_scan_nonempty, empty_removal, state_reg == S_EMIT, "empty table scanned")

endmodule

### rtl/cbit_ram.sv
// ----------------------------------------------------------------------------
// cbit_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cbit_ram #(
    parameter int WIDTH = 2 * cbit_pkg::DEF_VALUE_BITS,
    parameter int DEPTH = cbit_pkg::DEF_MAX_ENTRIES,
    parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### bench/capacity_bounded_item_table_top_test.sv
// ----------------------------------------------------------------------------
// capacity bounded item table testbench
// drives command beats and limit writes, mirrors the table in a local
// predictor and checks every result beat field by field, in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module capacity_bounded_item_table_top_test;

    import cbit_pkg::*;

    localparam int VB    = DEF_VALUE_BITS;
    localparam int IB    = DEF_INDEX_BITS;
    localparam int CB    = DEF_COUNT_BITS;
    localparam int NSLOT = DEF_MAX_ENTRIES;

    // command codes the block has no meaning for
    localparam logic [CMD_BITS-1:0] CMD_UNUSED_LO = 3'd5;
    localparam logic [CMD_BITS-1:0] CMD_UNUSED_HI = 3'd7;

    // settle margin: the worst result path is a full slot scan followed by a shift
    localparam int SETTLE_CYCLES = 2 * NSLOT + 8;
    localparam int CYCLE_LIMIT   = 1000000;

    typedef logic [VB-1:0] value_t;

    typedef struct {
        logic          done;
        value_t        vol;
        value_t        wt;
        logic [CB-1:0] count;
        value_t        used_vol;
        value_t        used_wt;
    } table_result_t;

    logic clk;
    logic rst_n;

    cbit_cmd_if cmd_bus ();
    cbit_res_if res_bus ();
    cbit_cfg_if cfg_bus ();

    capacity_bounded_item_table_top DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .res   (res_bus),
        .cfg   (cfg_bus)
    );

    // ------------------------------------------------------------------------
    // predictor state: a mirror of the entry list, totals and limits
    // ------------------------------------------------------------------------
    value_t held_vol [NSLOT];
    value_t held_wt  [NSLOT];
    int     held_n;
    value_t sum_vol;
    value_t sum_wt;
    value_t cap_vol;
    value_t cap_wt;

    // results predicted for accepted command beats, oldest first
    table_result_t pending_results[$];

    int  mismatch_count;
    int  cycle_count;
    bit  tx_idle_on;
    bit  rx_idle_on;
    int  rx_hold_cycles;

    // ------------------------------------------------------------------------
    // clock, reset and run limit
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // pull one entry out and close the gap behind it
    function automatic void take_entry(input int pos, output value_t vol, output value_t wt);
        vol = held_vol[pos];
        wt  = held_wt[pos];
        for (int k = pos; k + 1 < held_n; k++)
        begin
            held_vol[k] = held_vol[k + 1];
            held_wt[k]  = held_wt[k + 1];
        end
        held_n  = held_n - 1;
        sum_vol = sum_vol - vol;
        sum_wt  = sum_wt - wt;
    endfunction

    function automatic table_result_t predict_table_result(
        input logic [CMD_BITS-1:0] op,
        input value_t              vol,
        input value_t              wt,
        input logic [IB-1:0]       idx
    );
        table_result_t r;
        int            pick;
        logic [VB:0]   next_vol;
        logic [VB:0]   next_wt;
        r.done = 1'b0;
        r.vol  = '0;
        r.wt   = '0;
        case (op)
            CMD_ADD:
            begin
                // totals compared one bit wider, so no wraparound sneaks in
                next_vol = {1'b0, sum_vol} + {1'b0, vol};
                next_wt  = {1'b0, sum_wt} + {1'b0, wt};
                if (held_n < NSLOT && next_vol <= {1'b0, cap_vol}
                    && next_wt <= {1'b0, cap_wt})
                begin
                    held_vol[held_n] = vol;
                    held_wt[held_n]  = wt;
                    held_n           = held_n + 1;
                    sum_vol          = next_vol[VB-1:0];
                    sum_wt           = next_wt[VB-1:0];
                    r.done           = 1'b1;
                end
            end
            CMD_REMOVE_MIN, CMD_REMOVE_MAX:
            begin
                if (held_n > 0)
                begin
                    // strict compare keeps the lowest slot on ties
                    pick = 0;
                    for (int k = 1; k < held_n; k++)
                    begin
                        if (op == CMD_REMOVE_MAX ? (held_wt[k] > held_wt[pick])
                                                 : (held_wt[k] < held_wt[pick]))
                            pick = k;
                    end
                    take_entry(pick, r.vol, r.wt);
                    r.done = 1'b1;
                end
            end
            CMD_REMOVE_AT:
            begin
                if (idx < held_n)
                begin
                    take_entry(int'(idx), r.vol, r.wt);
                    r.done = 1'b1;
                end
            end
            CMD_READ:
            begin
                if (idx < held_n)
                begin
                    r.vol  = held_vol[idx];
                    r.wt   = held_wt[idx];
                    r.done = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        r.count    = CB'(held_n);
        r.used_vol = sum_vol;
        r.used_wt  = sum_wt;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // result side: random stall per beat, long hold on request, in-order check
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [63:0] exp_val,
                               input logic [63:0] act_val);
        if (act_val !== exp_val)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_val, act_val);
            mismatch_count++;
        end
    endtask

    initial
    begin : result_monitor
        int            stall;
        table_result_t want;
        res_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = rx_idle_on ? $urandom_range(0, 7) : 0;
            // a requested hold-off overrides the per-beat stall
            if (rx_hold_cycles > 0)
            begin
                stall          = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            if (stall > 0)
            begin
                res_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_bus.ready <= 1'b1;
            do
                @(posedge clk);
            while (res_bus.valid !== 1'b1);
            if (pending_results.size() == 0)
            begin
                $error("result beat with no command waiting for one");
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("done_res",     want.done,     res_bus.done_res);
                check_field("entry_volume", want.vol,      res_bus.entry_volume);
                check_field("entry_weight", want.wt,       res_bus.entry_weight);
                check_field("entry_count",  want.count,    res_bus.entry_count);
                check_field("used_volume",  want.used_vol, res_bus.used_volume);
                check_field("used_weight",  want.used_wt,  res_bus.used_weight);
            end
        end
    end

    // ------------------------------------------------------------------------
    // command side and limit writes
    // ------------------------------------------------------------------------

    // one command beat; returns at the edge where it was taken, valid left high
    task automatic send_item(input logic [CMD_BITS-1:0] op, input value_t vol,
                             input value_t wt, input logic [IB-1:0] idx);
        int            gap;
        table_result_t predicted;
        gap = tx_idle_on ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_bus.valid       <= 1'b1;
        cmd_bus.command     <= op;
        cmd_bus.item_volume <= vol;
        cmd_bus.item_weight <= wt;
        cmd_bus.item_index  <= idx;
        do
            @(posedge clk);
        while (cmd_bus.ready !== 1'b1);
        predicted = predict_table_result(op, vol, wt, idx);
        pending_results.insert(pending_results.size(), predicted);
    endtask

    // drop valid, let every expected result come back, then let the block settle
    task automatic wait_idle();
        cmd_bus.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // both limits, back to back on the config channel; block must be idle
    task automatic set_limits(input value_t vol_cap, input value_t wt_cap);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= REG_VOLUME_LIMIT;
        cfg_bus.data  <= vol_cap;
        do
            @(posedge clk);
        while (cfg_bus.ready !== 1'b1);
        cap_vol = vol_cap;
        cfg_bus.index <= REG_WEIGHT_LIMIT;
        cfg_bus.data  <= wt_cap;
        do
            @(posedge clk);
        while (cfg_bus.ready !== 1'b1);
        cap_wt = wt_cap;
        cfg_bus.valid <= 1'b0;
    endtask

    // mostly values up to span, with zero, all ones, full range and tie values mixed in
    function automatic value_t draw_value(input value_t span);
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            2:       return $urandom;
            3:       return value_t'($urandom_range(1, 4)) << 6;
            default: return $urandom_range(0, span);
        endcase
    endfunction

    task automatic send_random_item(input value_t span);
        int                  pick;
        logic [CMD_BITS-1:0] op;
        logic [IB-1:0]       idx;
        pick = $urandom_range(0, 99);
        if (pick < 42)
            op = CMD_ADD;
        else if (pick < 54)
            op = CMD_REMOVE_MIN;
        else if (pick < 66)
            op = CMD_REMOVE_MAX;
        else if (pick < 78)
            op = CMD_REMOVE_AT;
        else if (pick < 95)
            op = CMD_READ;
        else
            op = CMD_BITS'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
        // index mostly inside the held range, now and then anywhere
        if (held_n == 0 || $urandom_range(0, 7) == 0)
            idx = IB'($urandom_range(0, NSLOT - 1));
        else
            idx = IB'($urandom_range(0, held_n - 1));
        send_item(op, draw_value(span), draw_value(span), idx);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // zero limits only admit zero entries; empty table and unknown codes
    task automatic test_empty_and_zero_limits();
        set_limits('0, '0);
        send_item(CMD_ADD, '0, '0, '0);
        send_item(CMD_ADD, 32'h1, '0, '0);
        send_item(CMD_ADD, '0, 32'h1, '0);
        send_item(CMD_READ, $urandom, $urandom, '0);
        send_item(CMD_REMOVE_MIN, '0, '0, '0);
        send_item(CMD_REMOVE_MAX, '0, '0, '0);
        send_item(CMD_REMOVE_AT, '0, '0, '0);
        send_item(CMD_READ, '0, '0, '1);
        for (int c = CMD_UNUSED_LO; c <= CMD_UNUSED_HI; c++)
            send_item(CMD_BITS'(c), $urandom, $urandom, IB'($urandom_range(0, NSLOT - 1)));
        wait_idle();
    endtask

    // full-scale values, exact limit edges, out of range index, weight ties
    task automatic test_extremes_and_ties();
        set_limits('1, '1);
        send_item(CMD_ADD, '1, 32'h10, '0);
        send_item(CMD_ADD, 32'h1, '0, '0);          // volume one past the limit
        send_item(CMD_ADD, '0, '1 - 32'h10, '0);    // weight lands exactly on it
        send_item(CMD_ADD, '0, 32'h1, '0);
        send_item(CMD_READ, '0, '0, 5'd1);
        send_item(CMD_READ, '0, '0, '1);
        send_item(CMD_REMOVE_AT, '0, '0, 5'd2);
        send_item(CMD_REMOVE_MAX, '0, '0, '0);
        send_item(CMD_REMOVE_AT, '0, '0, '0);
        // two pairs of equal weights: lowest slot of each pair goes first
        send_item(CMD_ADD, 32'h1, 32'h80, '0);
        send_item(CMD_ADD, 32'h2, 32'h80, '0);
        send_item(CMD_ADD, 32'h3, 32'h100, '0);
        send_item(CMD_ADD, 32'h4, 32'h100, '0);
        send_item(CMD_REMOVE_MIN, '0, '0, '0);
        send_item(CMD_REMOVE_MAX, '0, '0, '0);
        send_item(CMD_REMOVE_AT, '0, '0, '0);
        send_item(CMD_READ, '0, '0, '0);
        send_item(CMD_REMOVE_MIN, '0, '0, '0);
        wait_idle();
    endtask

    // fill every slot, bounce off the full table, then drain it again
    task automatic test_fill_to_capacity();
        set_limits('1, '1);
        while (held_n < NSLOT)
            send_item(CMD_ADD, $urandom_range(0, 16'hFFFF), $urandom_range(0, 16'hFFFF),
                      IB'($urandom));
        send_item(CMD_ADD, '0, '0, '0);
        send_item(CMD_ADD, $urandom_range(1, 255), $urandom_range(1, 255), '0);
        send_item(CMD_READ, '0, '0, '1);
        send_item(CMD_REMOVE_AT, '0, '0, '1);
        send_item(CMD_READ, '0, '0, '1);
        send_item(CMD_REMOVE_AT, '0, '0, '0);
        while (held_n > 0)
            send_item($urandom_range(0, 1) ? CMD_REMOVE_MIN : CMD_REMOVE_MAX,
                      $urandom, $urandom, IB'($urandom));
        wait_idle();
    endtask

    task automatic test_random_mix(input int n, input value_t vol_cap, input value_t wt_cap,
                                   input value_t span, input bit idle);
        set_limits(vol_cap, wt_cap);
        tx_idle_on = idle;
        rx_idle_on = idle;
        repeat (n) send_random_item(span);
        wait_idle();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // limits dropped under the held totals: entries stay, adds must fail
    task automatic test_lowered_limits();
        set_limits(32'h0000_4000, 32'h0000_4000);
        repeat (8)
            send_item(CMD_ADD, $urandom_range(32'h100, 32'h800),
                      $urandom_range(32'h100, 32'h800), '0);
        wait_idle();
        set_limits(32'h0000_0100, '0);
        send_item(CMD_ADD, '0, '0, '0);
        send_item(CMD_ADD, 32'h1, '0, '0);
        send_item(CMD_READ, '0, '0, '0);
        send_item(CMD_REMOVE_MAX, '0, '0, '0);
        send_item(CMD_REMOVE_MIN, '0, '0, '0);
        repeat (60) send_random_item(32'h80);
        wait_idle();
    endtask

    // result side held off for a long stretch while commands keep coming
    task automatic test_backpressure();
        set_limits('1, '1);
        tx_idle_on     = 1'b0;
        rx_hold_cycles = 400;
        repeat (80) send_random_item(32'h0000_FFFF);
        wait_idle();
        tx_idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n               <= 1'b0;
        cmd_bus.valid       <= 1'b0;
        cmd_bus.command     <= CMD_ADD;
        cmd_bus.item_volume <= '0;
        cmd_bus.item_weight <= '0;
        cmd_bus.item_index  <= '0;
        cfg_bus.valid       <= 1'b0;
        cfg_bus.index       <= REG_VOLUME_LIMIT;
        cfg_bus.data        <= '0;
        mismatch_count = 0;
        cycle_count    = 0;
        rx_hold_cycles = 0;
        tx_idle_on     = 1'b1;
        rx_idle_on     = 1'b1;
        held_n         = 0;
        sum_vol        = '0;
        sum_wt         = '0;
        cap_vol        = '0;
        cap_wt         = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_empty_and_zero_limits();
        test_extremes_and_ties();
        test_fill_to_capacity();
        test_random_mix(350, '1, '1, 32'h0000_FFFF, 1'b1);
        test_random_mix(250, 32'h0004_0000, 32'h0002_0000, 32'h0000_3000, 1'b1);
        test_lowered_limits();
        test_backpressure();
        test_random_mix(200, $urandom >> $urandom_range(0, 24),
                        $urandom >> $urandom_range(0, 24), 32'h0000_8000, 1'b0);
        test_random_mix(200, '1, 32'h8000_0000, '1, 1'b1);

        if (pending_results.size() != 0)
        begin
            $error("%0d results never arrived", pending_results.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
